### hdl/sli_pkg.sv
package sli_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned POS_W     = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] val;
  } cell_ctrl_t;

endpackage

### hdl/sli_cell.sv
module sli_cell (
  input  logic                                clk_i,
  input  sli_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                occ_i,
  input  logic                                left_le_i,
  input  logic signed [sli_pkg::VAL_W-1:0]    left_entry_i,
  input  logic signed [sli_pkg::VAL_W-1:0]    right_entry_i,
  output logic signed [sli_pkg::VAL_W-1:0]    entry_o,
  output logic                                le_o,
  output logic                                lt_o,
  output logic                                eq_o
);
  import sli_pkg::*;

  logic signed [VAL_W-1:0] entry_q, entry_d;

  assign entry_o = entry_q;
  assign le_o    = occ_i && (entry_q <= ctrl_i.val);
  assign lt_o    = occ_i && (entry_q <  ctrl_i.val);
  assign eq_o    = occ_i && (entry_q == ctrl_i.val);

  // Insert: keep below the slot, load at the slot, take the left neighbor above it.
  // Delete: from the removed slot on, take the right neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!le_o) begin
        entry_d = left_le_i ? ctrl_i.val : left_entry_i;
      end
    end else if (ctrl_i.del) begin
      if (!lt_o) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### hdl/sli_encode.sv
module sli_encode #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF,
  parameter int unsigned PW    = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0]                            sel_i,
  input  logic signed [DEPTH-1:0][sli_pkg::VAL_W-1:0] data_i,
  output logic [PW-1:0]                               index_o,
  output logic signed [sli_pkg::VAL_W-1:0]            data_o
);
  import sli_pkg::*;

  // One-hot select: OR together the index and the data of the selected cell.
  always_comb begin
    index_o = '0;
    data_o  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_i[i]) begin
        index_o = index_o | PW'(i);
        data_o  = data_o | data_i[i];
      end
    end
  end

endmodule

### hdl/sorted_list_insert_delete.sv
// Sorted list: keeps up to DEPTH signed 32-bit values in ascending order.
// Command channel: opcode_i, value_i and index_i transfer at a rising edge
// with start high and busy low. busy stays low, so a command may transfer
// at every edge. Opcodes: insert (after equal values), delete (first equal
// value), read (entry at index); the unused code only reports the count.
// Result channel: done_o is high for exactly one cycle per command, with
// status_o, count_o, position_o and read_value_o valid in that cycle; the
// receiver takes it at the edge ending the cycle and cannot hold it off.
// A command passes through the command register and then the result
// register. Throughput: one command per cycle. The command register feeds
// a chain of cells; every cell compares its entry against the value, and
// shifts toward or away from its neighbor in the same cycle, so each
// command sees the list that the previous one left.
// Position and read data come from a one-hot OR across the chain.
// Reset clears the count and the result strobe; entries stay unwritten
// and are never read before a write.
module sorted_list_insert_delete #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sli_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [sli_pkg::VAL_W-1:0]  value_i,
  input  logic [sli_pkg::IDX_W-1:0]         index_i,
  output logic                              done_o,
  output logic [sli_pkg::ST_W-1:0]          status_o,
  output logic [sli_pkg::CNT_W-1:0]         count_o,
  output logic [sli_pkg::POS_W-1:0]         position_o,
  output logic signed [sli_pkg::VAL_W-1:0]  read_value_o
);
  import sli_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);

  // Command register
  logic                    cmd_vld_q;
  op_e                     op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [IDX_W-1:0]        idx_q;
  logic [CW-1:0]           count_q, count_d;

  // Result register
  logic                    res_vld_q;
  status_e                 status_q, status_d;
  logic [CW-1:0]           res_count_q;
  logic [PW-1:0]           pos_q, pos_d;
  logic signed [VAL_W-1:0] rd_q, rd_d;

  // Chain
  cell_ctrl_t                         ctrl;
  logic [DEPTH-1:0]                   occ, le, lt, eq, bnd, hit, sel;
  logic signed [DEPTH-1:0][VAL_W-1:0] entry;
  logic                               full, found, read_ok;
  logic [PW-1:0]                      enc_idx;
  logic signed [VAL_W-1:0]            enc_data;

  assign busy = 1'b0;

  // Hold the command in the command register while the chain works on it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q  <= op_e'(opcode_i);
      val_q <= value_i;
      idx_q <= index_i;
    end
  end

  assign full    = (count_q == CW'(DEPTH));
  assign found   = |eq;
  assign read_ok = int'(idx_q) < int'(count_q);

  assign ctrl.ins = cmd_vld_q && (op_q == OP_INSERT) && !full;
  assign ctrl.del = cmd_vld_q && (op_q == OP_DELETE) && found;
  assign ctrl.val = val_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_le;
    logic signed [VAL_W-1:0] left_entry, right_entry;

    assign occ[i] = count_q > CW'(i);
    assign hit[i] = (int'(idx_q) == i);

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = val_q;
      assign bnd[i]     = (op_q == OP_INSERT) ? !le[i] : !lt[i];
    end else begin : g_rest
      assign left_le    = le[i-1];
      assign left_entry = entry[i-1];
      assign bnd[i]     = (op_q == OP_INSERT) ? (le[i-1] && !le[i]) : (lt[i-1] && !lt[i]);
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_mid
      assign right_entry = entry[i+1];
    end

    sli_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .left_le_i     (left_le),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .le_o          (le[i]),
      .lt_o          (lt[i]),
      .eq_o          (eq[i])
    );
  end

  // Read selects by index, insert and delete by the compare boundary.
  assign sel = (op_q == OP_READ) ? hit : bnd;

  sli_encode #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_encode (
    .sel_i   (sel),
    .data_i  (entry),
    .index_o (enc_idx),
    .data_o  (enc_data)
  );

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    pos_d    = '0;
    rd_d     = '0;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
          pos_d   = enc_idx;
        end
      end
      OP_DELETE: begin
        if (!found) begin
          status_d = ST_ABSENT;
        end else begin
          count_d = count_q - CW'(1);
          pos_d   = enc_idx;
        end
      end
      OP_READ: begin
        if (!read_ok) begin
          status_d = ST_RANGE;
        end else begin
          pos_d = enc_idx;
          rd_d  = enc_data;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_vld_q;
      if (cmd_vld_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_vld_q) begin
      status_q    <= status_d;
      res_count_q <= count_d;
      pos_q       <= pos_d;
      rd_q        <= rd_d;
    end
  end

  assign done_o       = res_vld_q;
  assign status_o     = status_q;
  assign count_o      = CNT_W'(res_count_q);
  assign position_o   = POS_W'(pos_q);
  assign read_value_o = rd_q;

endmodule

### hdl/sli_checker.sv
module sli_protocol_checker #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic [sli_pkg::ST_W-1:0]          status_o,
  input logic [sli_pkg::CNT_W-1:0]         count_o,
  input logic [sli_pkg::POS_W-1:0]         position_o,
  input logic signed [sli_pkg::VAL_W-1:0]  read_value_o
);
  import sli_pkg::*;

  // One result per transfer, after the command and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 2) && $past(rst_ni, 1) && $past(start && !busy, 2) |-> done_o)
    else $error("command transfer without result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without command transfer");

  // A refused command reports position and data as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (position_o == '0) && (read_value_o == '0))
    else $error("failed command reports nonzero position or data");

  // Back-to-back results move the count by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) |->
      (count_o == $past(count_o)) || (count_o == $past(count_o) + 5'd1) ||
      (count_o == $past(count_o) - 5'd1))
    else $error("count jumped by more than one");

  // A full refusal only happens at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> (count_o == CNT_W'(DEPTH)))
    else $error("full status below capacity");

endmodule

bind sorted_list_insert_delete sli_protocol_checker #(.DEPTH(DEPTH)) u_sli_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .count_o      (count_o),
  .position_o   (position_o),
  .read_value_o (read_value_o)
);
